// File: hw/rtl/idr_pkg.sv
// Shared types and constants of the interrupt distributor register bank.
// Payload structs, operation codes, region codes and memory layout helpers.
// No dependencies.
`default_nettype none

package idr_pkg;

  localparam int VM_W = 2;

  localparam logic        ACT_READ  = 1'b0;
  localparam logic        ACT_WRITE = 1'b1;

  localparam logic [1:0]  SZ_BYTE = 2'd0;
  localparam logic [1:0]  SZ_HALF = 2'd1;
  localparam logic [1:0]  SZ_WORD = 2'd2;
  localparam logic [1:0]  SZ_RSVD = 2'd3;

  localparam logic        STATUS_OK  = 1'b0;
  localparam logic        STATUS_BAD = 1'b1;

  // 256-byte pages of the distributor window
  localparam logic [3:0]  PG_CTRL   = 4'h0;
  localparam logic [3:0]  PG_ENABLE = 4'h1;
  localparam logic [3:0]  PG_PEND   = 4'h2;
  localparam logic [3:0]  PG_PRI_LO = 4'h4;
  localparam logic [3:0]  PG_PRI_HI = 4'h7;
  localparam logic [3:0]  PG_TGT_LO = 4'h8;
  localparam logic [3:0]  PG_TGT_HI = 4'hB;
  localparam logic [3:0]  PG_CFG    = 4'hC;

  // word indexes inside the control page
  localparam logic [9:0]  W_CTLR  = 10'h000;
  localparam logic [9:0]  W_TYPER = 10'h001;
  localparam logic [9:0]  W_IIDR  = 10'h002;
  localparam logic [4:0]  GRP_SEL = 5'h01;   // words 0x20..0x3F

  localparam logic [31:0] IIDR_VALUE = 32'h0000_043B;

  typedef struct packed {
    logic        action;
    logic [1:0]  vm_id;
    logic [11:0] byte_offset;
    logic [1:0]  acc_size;
    logic [31:0] write_data;
  } idr_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
    logic        enable_changed;
    logic [31:0] changed_value;
    logic [1:0]  changed_word;
    logic [1:0]  changed_vm;
  } idr_rsp_t;

  typedef enum logic [3:0] {
    OP_BAD,
    OP_NOP,
    OP_WORD,
    OP_TYPER,
    OP_IIDR,
    OP_ENA_SET,
    OP_ENA_CLR,
    OP_PND_SET,
    OP_PND_CLR,
    OP_TARGET
  } idr_op_kind_t;

  typedef struct packed {
    idr_op_kind_t kind;
    logic         wr;
    logic [1:0]   size;
    logic [1:0]   lane;
    logic [1:0]   vm;
    logic [1:0]   word_lo;
    logic         locked;    // target words 0..7 ignore writes
    logic [31:0]  wdata;
  } idr_op_t;

  typedef struct packed {
    logic        en;
    logic [31:0] data;
  } idr_wb_t;

  function automatic int idr_idx_w(input int words);
    return (words > 1) ? $clog2(words) : 1;
  endfunction

  // one region holds every VM's copy of one register array
  function automatic int idr_region(input int words);
    return 1 << (VM_W + idr_idx_w(words));
  endfunction

  function automatic int idr_mem_depth(input int lines);
    return (1 << VM_W) + 3 * idr_region(lines / 32) + 2 * idr_region(lines / 4)
           + idr_region(lines / 16);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/idr_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on idr_pkg for the payload structs.
`default_nettype none

interface idr_req_if import idr_pkg::*; ();
  logic     valid;
  logic     ready;
  idr_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface idr_rsp_if import idr_pkg::*; ();
  logic     valid;
  logic     ready;
  idr_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/idr_decode.sv
// Address decode: turns a request into an operation code and a word address.
// Depends on idr_pkg.
`default_nettype none

module idr_decode import idr_pkg::*; #(
  parameter int NUM_VMS   = 4,
  parameter int INT_LINES = 128,
  parameter int ADDR_W    = 9
) (
  input  idr_req_t          req,
  output idr_op_t           op,
  output logic [ADDR_W-1:0] addr
);

  localparam int GRP_WORDS = INT_LINES / 32;
  localparam int PRI_WORDS = INT_LINES / 4;
  localparam int CFG_WORDS = INT_LINES / 16;
  localparam int GRP_IW    = idr_idx_w(GRP_WORDS);
  localparam int PRI_IW    = idr_idx_w(PRI_WORDS);
  localparam int CFG_IW    = idr_idx_w(CFG_WORDS);

  localparam int CTL_BASE = 0;
  localparam int GRP_BASE = CTL_BASE + (1 << VM_W);
  localparam int ENA_BASE = GRP_BASE + idr_region(GRP_WORDS);
  localparam int PND_BASE = ENA_BASE + idr_region(GRP_WORDS);
  localparam int PRI_BASE = PND_BASE + idr_region(GRP_WORDS);
  localparam int TGT_BASE = PRI_BASE + idr_region(PRI_WORDS);
  localparam int CFG_BASE = TGT_BASE + idr_region(PRI_WORDS);

  logic [9:0] wrd;
  logic [3:0] page;
  logic       grp_hit;
  logic       pri_hit;
  logic       cfg_hit;

  assign wrd     = req.byte_offset[11:2];
  assign page    = req.byte_offset[11:8];
  assign grp_hit = 32'(wrd[4:0]) < GRP_WORDS;
  assign pri_hit = 32'(wrd[7:0]) < PRI_WORDS;
  assign cfg_hit = 32'(wrd[5:0]) < CFG_WORDS;

  always_comb begin
    op.kind    = OP_BAD;
    op.wr      = (req.action == ACT_WRITE);
    op.size    = req.acc_size;
    op.lane    = req.byte_offset[1:0];
    op.vm      = req.vm_id;
    op.word_lo = wrd[1:0];
    op.locked  = (wrd[7:3] == 5'd0);
    op.wdata   = req.write_data;
    addr       = '0;

    if (32'(req.vm_id) < NUM_VMS) begin
      if (page == PG_CTRL) begin
        if (wrd == W_CTLR) begin
          op.kind = OP_WORD;
          addr    = ADDR_W'(CTL_BASE) + ADDR_W'(req.vm_id);
        end else if (wrd == W_TYPER) begin
          if (!op.wr) op.kind = OP_TYPER;
        end else if (wrd == W_IIDR) begin
          if (!op.wr) op.kind = OP_IIDR;
        end else if (wrd[9:5] == GRP_SEL && grp_hit) begin
          op.kind = OP_WORD;
          addr    = ADDR_W'(GRP_BASE) + ADDR_W'({req.vm_id, wrd[GRP_IW-1:0]});
        end
      end else if (page == PG_ENABLE) begin
        // zero write to the enable page is a successful no-op anywhere
        if (op.wr && req.write_data == 32'd0) begin
          op.kind = OP_NOP;
        end else if (req.acc_size != SZ_RSVD && grp_hit) begin
          op.kind = wrd[5] ? OP_ENA_CLR : OP_ENA_SET;
          addr    = ADDR_W'(ENA_BASE) + ADDR_W'({req.vm_id, wrd[GRP_IW-1:0]});
        end
      end else if (page == PG_PEND) begin
        if (req.acc_size == SZ_WORD && grp_hit) begin
          op.kind = wrd[5] ? OP_PND_CLR : OP_PND_SET;
          addr    = ADDR_W'(PND_BASE) + ADDR_W'({req.vm_id, wrd[GRP_IW-1:0]});
        end
      end else if (page inside {[PG_PRI_LO:PG_PRI_HI]}) begin
        if (pri_hit) begin
          op.kind = OP_WORD;
          addr    = ADDR_W'(PRI_BASE) + ADDR_W'({req.vm_id, wrd[PRI_IW-1:0]});
        end
      end else if (page inside {[PG_TGT_LO:PG_TGT_HI]}) begin
        if (pri_hit) begin
          op.kind = (req.acc_size == SZ_RSVD) ? OP_NOP : OP_TARGET;
          addr    = ADDR_W'(TGT_BASE) + ADDR_W'({req.vm_id, wrd[PRI_IW-1:0]});
        end
      end else if (page == PG_CFG) begin
        if (cfg_hit) begin
          op.kind = OP_WORD;
          addr    = ADDR_W'(CFG_BASE) + ADDR_W'({req.vm_id, wrd[CFG_IW-1:0]});
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/idr_bank.sv
// Word store for all register arrays: two-port (read, write) memory, clear
// sweep after reset, registered read, last-write forwarding. Depends on idr_pkg.
`default_nettype none

module idr_bank import idr_pkg::*; #(
  parameter int DEPTH  = 340,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  idr_wb_t           wb,
  output logic [31:0]       q,
  output logic              ready
);

  logic [31:0]       mem [DEPTH];
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] addr_r;
  logic [31:0]       rdata_r;
  logic              lw_valid_r;
  logic [ADDR_W-1:0] lw_addr_r;
  logic [31:0]       lw_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      lw_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) clr_busy_r <= 1'b0;
      end
      if (clr_busy_r || wb.en) lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_r  <= rd_addr;
      rdata_r <= mem[rd_addr];
    end
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 32'd0;
      lw_addr_r      <= clr_cnt_r;
      lw_data_r      <= 32'd0;
    end else if (wb.en) begin
      mem[addr_r] <= wb.data;
      lw_addr_r   <= addr_r;
      lw_data_r   <= wb.data;
    end
  end

  // read and write of one word in the same cycle: take the written value
  assign q     = (lw_valid_r && lw_addr_r == addr_r) ? lw_data_r : rdata_r;
  assign ready = !clr_busy_r;

endmodule

`default_nettype wire

// File: hw/rtl/idr_exec.sv
// Executes one decoded access on the fetched word: read data, status,
// enable change report and write-back value. Depends on idr_pkg.
`default_nettype none

module idr_exec import idr_pkg::*; #(
  parameter int INT_LINES = 128
) (
  input  idr_op_t     op,
  input  logic [31:0] q,
  output idr_rsp_t    rsp,
  output idr_wb_t     wb
);

  localparam logic [31:0] TYPER_VALUE = 32'((INT_LINES >> 5) - 1);

  logic [31:0] mask;
  logic [4:0]  shamt;
  logic [31:0] lane_val;
  logic [31:0] wmask;
  logic [31:0] new_lane;

  always_comb begin
    case (op.size)
      SZ_BYTE: begin
        mask  = 32'h0000_00FF;
        shamt = {op.lane, 3'b000};
      end
      SZ_HALF: begin
        mask  = 32'h0000_FFFF;
        shamt = {op.lane[1], 4'b0000};
      end
      default: begin
        mask  = 32'hFFFF_FFFF;
        shamt = 5'd0;
      end
    endcase
  end

  assign lane_val = (q >> shamt) & mask;
  assign wmask    = op.wdata & mask;
  assign new_lane = (op.kind == OP_ENA_SET) ? (lane_val | wmask) : (lane_val & ~wmask & mask);

  always_comb begin
    rsp        = '0;
    rsp.status = STATUS_OK;
    wb         = '0;
    case (op.kind)
      OP_BAD: rsp.status = STATUS_BAD;
      OP_NOP: ;
      OP_WORD: begin
        if (op.wr) begin
          wb.en   = 1'b1;
          wb.data = op.wdata;
        end else begin
          rsp.read_data = q;
        end
      end
      OP_TYPER: rsp.read_data = TYPER_VALUE;
      OP_IIDR:  rsp.read_data = IIDR_VALUE;
      OP_ENA_SET, OP_ENA_CLR: begin
        if (op.wr) begin
          wb.en              = 1'b1;
          wb.data            = (q & ~(mask << shamt)) | (new_lane << shamt);
          rsp.enable_changed = 1'b1;
          rsp.changed_value  = new_lane;
          rsp.changed_word   = op.word_lo;
          rsp.changed_vm     = op.vm;
        end else begin
          rsp.read_data = lane_val;
        end
      end
      OP_PND_SET, OP_PND_CLR: begin
        if (op.wr) begin
          wb.en   = 1'b1;
          wb.data = (op.kind == OP_PND_SET) ? (q | op.wdata) : (q & ~op.wdata);
        end else begin
          rsp.read_data = q;
        end
      end
      OP_TARGET: begin
        if (op.wr) begin
          wb.en   = !op.locked;
          wb.data = (q & ~(mask << shamt)) | (wmask << shamt);
        end else begin
          rsp.read_data = lane_val;
        end
      end
      default: rsp.status = STATUS_BAD;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/interrupt_distributor_registers_top.sv
// Top level of the per-VM interrupt distributor register bank.
// Depends on idr_pkg, idr_if, idr_decode, idr_bank and idr_exec.
//
//  channel | dir | payload   | transfer when
//  --------+-----+-----------+-----------------------------
//  in_ch   | in  | idr_req_t | in_ch.valid && in_ch.ready
//  out_ch  | out | idr_rsp_t | out_ch.valid && out_ch.ready
//
// One access per cycle on each channel while out_ch accepts; a request's word
// is read from memory at its transfer edge while its op enters the execute
// stage, and the execute result is then registered into the output reg.
// The word memory has separate read and write ports: one read at the request
// transfer, one write as the access leaves the execute stage.
// Reset (rst_n, synchronous) starts a clear sweep of all idr_mem_depth(INT_LINES)
// words (340 at the defaults), one word a cycle, with in_ch.ready low.
// A stall on out_ch parks one response in the output register and one access
// in the execute stage; in_ch.ready then drops until out_ch drains.
`default_nettype none

module interrupt_distributor_registers_top import idr_pkg::*; #(
  parameter int NUM_VMS   = 4,
  parameter int INT_LINES = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  idr_req_if.sink   in_ch,
  idr_rsp_if.source out_ch
);

  localparam int MEM_DEPTH = idr_mem_depth(INT_LINES);
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  idr_op_t           dec_op;
  logic [ADDR_W-1:0] dec_addr;
  logic              bank_ready;
  logic [31:0]       bank_q;
  idr_rsp_t          exec_rsp;
  idr_wb_t           exec_wb;
  idr_wb_t           bank_wb;

  logic              s1_valid_r;
  idr_op_t           s1_op_r;
  logic              out_valid_r;
  idr_rsp_t          out_data_r;

  logic              s1_adv;
  logic              in_ready;
  logic              in_xfer;

  // execute stage moves on when the output register is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = bank_ready && (!s1_valid_r || s1_adv);
  assign in_xfer  = in_ch.valid && in_ready;

  idr_decode #(
    .NUM_VMS   (NUM_VMS),
    .INT_LINES (INT_LINES),
    .ADDR_W    (ADDR_W)
  ) u_decode (
    .req  (in_ch.data),
    .op   (dec_op),
    .addr (dec_addr)
  );

  // memory read is issued on the request transfer itself
  idr_bank #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (dec_addr),
    .wb      (bank_wb),
    .q       (bank_q),
    .ready   (bank_ready)
  );

  idr_exec #(
    .INT_LINES (INT_LINES)
  ) u_exec (
    .op  (s1_op_r),
    .q   (bank_q),
    .rsp (exec_rsp),
    .wb  (exec_wb)
  );

  // write back only as the access leaves, so a stalled access commits once
  assign bank_wb.en   = exec_wb.en && s1_adv;
  assign bank_wb.data = exec_wb.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_ch.valid;
      if (!out_valid_r || out_ch.ready) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s1_op_r <= dec_op;
    if (s1_adv)  out_data_r <= exec_rsp;
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r && (out_data_r == $past(exec_rsp)))
    else $error("execute result not captured in output register");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !bank_ready |-> !s1_valid_r && !out_valid_r)
    else $error("access in flight during clear sweep");

  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == STATUS_BAD
      |-> out_data_r.read_data == 32'd0 && !out_data_r.enable_changed)
    else $error("bad access returned data or a change report");

  a_chg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.enable_changed
      |-> out_data_r.changed_value == 32'd0 && out_data_r.changed_word == 2'd0
          && out_data_r.changed_vm == 2'd0)
    else $error("change fields set without enable change");

endmodule

`default_nettype wire

// File: tb/interrupt_distributor_registers_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for interrupt_distributor_registers_top: a directed access table,
// then weighted random accesses, all checked against an in-bench register mirror.
// Depends on idr_pkg, idr_if and the RTL of the register bank.

module interrupt_distributor_registers_top_tb;
  import idr_pkg::*;

  // Geometry at the block's default parameters
  localparam int VMS       = 4;
  localparam int LINES     = 128;
  localparam int GRP_WORDS = LINES / 32;
  localparam int PRI_WORDS = LINES / 4;
  localparam int CFG_WORDS = LINES / 16;

  // Word indexes (byte_offset / 4) where each register array starts
  localparam int GRP_BASE     = 'h020;
  localparam int ENA_SET_BASE = 'h040;
  localparam int ENA_CLR_BASE = 'h060;
  localparam int PND_SET_BASE = 'h080;
  localparam int PND_CLR_BASE = 'h0A0;
  localparam int PRI_BASE     = 'h100;
  localparam int TGT_BASE     = 'h200;
  localparam int CFG_BASE     = 'h300;
  localparam int TGT_LOCKED   = 7;      // target words 0..7 drop writes

  localparam int RANDOM_ACCESSES = 900;
  localparam int FLOOD_START     = 300;
  localparam int FLOOD_END       = 360;
  localparam int QUIET_POINT     = 600;
  localparam int HOLD_CYCLES     = 200;
  localparam int DRAIN_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 200_000;

  localparam idr_rsp_t RSP_OK  = '0;
  localparam idr_rsp_t RSP_BAD = '{read_data: 32'h0, status: STATUS_BAD, default: '0};

  // One row of the directed table: the access and, where it is obvious,
  // the reply typed in by hand.  Rows with known = 0 go to the mirror.
  typedef struct packed {
    idr_req_t req;
    logic     known;
    idr_rsp_t rsp;
  } access_row_t;

  typedef struct packed {
    logic     known;
    idr_rsp_t rsp;
  } fixed_reply_t;

  localparam int PLAN_LEN = 26;
  localparam access_row_t ACCESS_PLAN [PLAN_LEN] = '{
    // control page straight after reset
    '{'{ACT_READ,  2'd0, 12'h000, SZ_WORD, 32'h0}, 1'b1, RSP_OK},
    '{'{ACT_READ,  2'd1, 12'h004, SZ_WORD, 32'h0}, 1'b1,
      '{32'd3, STATUS_OK, 1'b0, 32'h0, 2'd0, 2'd0}},
    '{'{ACT_READ,  2'd2, 12'h008, SZ_BYTE, 32'h0}, 1'b1,
      '{IIDR_VALUE, STATUS_OK, 1'b0, 32'h0, 2'd0, 2'd0}},
    // read-only words refuse writes, CTLR takes one
    '{'{ACT_WRITE, 2'd0, 12'h004, SZ_WORD, 32'hFFFF_FFFF}, 1'b1, RSP_BAD},
    '{'{ACT_WRITE, 2'd3, 12'h008, SZ_WORD, 32'h1234_5678}, 1'b1, RSP_BAD},
    '{'{ACT_WRITE, 2'd3, 12'h000, SZ_WORD, 32'hFFFF_FFFF}, 1'b1, RSP_OK},
    // last group word, written then read with a byte access
    '{'{ACT_WRITE, 2'd2, 12'h08C, SZ_WORD, 32'hDEAD_BEEF}, 1'b1, RSP_OK},
    '{'{ACT_READ,  2'd2, 12'h08D, SZ_BYTE, 32'h0}, 1'b0, RSP_OK},
    // enables: top byte lane set, read back, half lane cleared
    '{'{ACT_WRITE, 2'd1, 12'h103, SZ_BYTE, 32'hFFFF_FFFF}, 1'b1,
      '{32'h0, STATUS_OK, 1'b1, 32'h0000_00FF, 2'd0, 2'd1}},
    '{'{ACT_READ,  2'd1, 12'h100, SZ_WORD, 32'h0}, 1'b0, RSP_OK},
    '{'{ACT_WRITE, 2'd1, 12'h182, SZ_HALF, 32'h0000_FFFF}, 1'b0, RSP_OK},
    // zero write anywhere in the enable page, even unmapped with size 3
    '{'{ACT_WRITE, 2'd2, 12'h1FC, SZ_RSVD, 32'h0}, 1'b1, RSP_OK},
    // lane bits all zero but the rest set: still reported as a change
    '{'{ACT_WRITE, 2'd2, 12'h10D, SZ_BYTE, 32'hFFFF_FF00}, 1'b1,
      '{32'h0, STATUS_OK, 1'b1, 32'h0, 2'd3, 2'd2}},
    '{'{ACT_WRITE, 2'd0, 12'h104, SZ_RSVD, 32'h0000_0001}, 1'b1, RSP_BAD},
    // pending: set, clear, read back, then a size-3 access
    '{'{ACT_WRITE, 2'd0, 12'h20C, SZ_WORD, 32'hFFFF_FFFF}, 1'b1, RSP_OK},
    '{'{ACT_WRITE, 2'd0, 12'h28C, SZ_WORD, 32'h0F0F_0F0F}, 1'b0, RSP_OK},
    '{'{ACT_READ,  2'd0, 12'h28C, SZ_WORD, 32'h0}, 1'b0, RSP_OK},
    '{'{ACT_READ,  2'd0, 12'h20D, SZ_RSVD, 32'h0}, 1'b1, RSP_BAD},
    // last priority word
    '{'{ACT_WRITE, 2'd3, 12'h47C, SZ_WORD, 32'hFFFF_FFFF}, 1'b1, RSP_OK},
    '{'{ACT_READ,  2'd3, 12'h47C, SZ_HALF, 32'h0}, 1'b0, RSP_OK},
    // targets: locked word drops the write, byte lane on word 8
    '{'{ACT_WRITE, 2'd0, 12'h800, SZ_WORD, 32'hFFFF_FFFF}, 1'b1, RSP_OK},
    '{'{ACT_READ,  2'd0, 12'h800, SZ_WORD, 32'h0}, 1'b1, RSP_OK},
    '{'{ACT_WRITE, 2'd1, 12'h821, SZ_BYTE, 32'h0000_00AB}, 1'b1, RSP_OK},
    '{'{ACT_READ,  2'd1, 12'h820, SZ_WORD, 32'h0}, 1'b0, RSP_OK},
    // last trigger config word; active page and SGIR page are unimplemented
    '{'{ACT_WRITE, 2'd2, 12'hC1C, SZ_WORD, 32'h5555_5555}, 1'b0, RSP_OK},
    '{'{ACT_WRITE, 2'd3, 12'hFFF, SZ_RSVD, 32'hFFFF_FFFF}, 1'b1, RSP_BAD}
  };

  logic clk;
  logic rst_n;

  idr_req_if in_ch ();
  idr_rsp_if out_ch ();

  interrupt_distributor_registers_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the register bank, one slice per VM
  logic [31:0] ctlr_mirror    [VMS];
  logic [31:0] group_mirror   [VMS * GRP_WORDS];
  logic [31:0] enable_mirror  [VMS * GRP_WORDS];
  logic [31:0] pending_mirror [VMS * GRP_WORDS];
  logic [31:0] prio_mirror    [VMS * PRI_WORDS];
  logic [31:0] target_mirror  [VMS * PRI_WORDS];
  logic [31:0] trigger_mirror [VMS * CFG_WORDS];

  fixed_reply_t fixed_replies [$];   // one per offered access, in order
  idr_rsp_t     replies_due   [$];   // expected replies, oldest first

  int  mismatches = 0;
  int  cycle_count;
  int  rx_count = 0;
  bit  calm_in;
  bit  flood;
  bit  hold_out;

  // Works out the reply to one access and applies its write to the mirror.
  function automatic idr_rsp_t predict_access(input idr_req_t a);
    idr_rsp_t    r;
    logic [9:0]  w;
    logic [3:0]  page;
    logic [31:0] m;
    logic [31:0] lane;
    logic [31:0] wd;
    logic        wr;
    logic        set_hit;
    logic        clr_hit;
    int          sh;
    int          idx;
    int          slot;
    r      = '0;
    r.status = STATUS_BAD;
    wr     = (a.action == ACT_WRITE);
    wd     = a.write_data;
    w      = a.byte_offset[11:2];
    page   = a.byte_offset[11:8];
    m      = (a.acc_size == SZ_BYTE) ? 32'h0000_00FF :
             (a.acc_size == SZ_HALF) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    sh     = (a.acc_size == SZ_BYTE) ? 8 * a.byte_offset[1:0] :
             (a.acc_size == SZ_HALF) ? 16 * a.byte_offset[1] : 0;

    if (page == PG_CTRL) begin
      if (w == W_CTLR) begin
        if (wr) ctlr_mirror[a.vm_id] = wd;
        else r.read_data = ctlr_mirror[a.vm_id];
        r.status = STATUS_OK;
      end else if (w == W_TYPER || w == W_IIDR) begin
        if (!wr) begin
          r.read_data = (w == W_TYPER) ? 32'(LINES / 32 - 1) : IIDR_VALUE;
          r.status    = STATUS_OK;
        end
      end else if (w >= GRP_BASE && w < GRP_BASE + GRP_WORDS) begin
        slot = a.vm_id * GRP_WORDS + (w - GRP_BASE);
        if (wr) group_mirror[slot] = wd;
        else r.read_data = group_mirror[slot];
        r.status = STATUS_OK;
      end
    end else if (page == PG_ENABLE) begin
      if (wr && wd == 32'h0) begin
        r.status = STATUS_OK;        // zero write is a no-op anywhere here
      end else if (a.acc_size != SZ_RSVD) begin
        set_hit = (w >= ENA_SET_BASE && w < ENA_SET_BASE + GRP_WORDS);
        clr_hit = (w >= ENA_CLR_BASE && w < ENA_CLR_BASE + GRP_WORDS);
        if (set_hit || clr_hit) begin
          idx  = set_hit ? w - ENA_SET_BASE : w - ENA_CLR_BASE;
          slot = a.vm_id * GRP_WORDS + idx;
          lane = (enable_mirror[slot] >> sh) & m;
          if (wr) begin
            lane = set_hit ? (lane | (wd & m)) : (lane & ~(wd & m) & m);
            enable_mirror[slot] = (enable_mirror[slot] & ~(m << sh)) | (lane << sh);
            r.enable_changed = 1'b1;
            r.changed_value  = lane;
            r.changed_word   = idx[1:0];
            r.changed_vm     = a.vm_id;
          end else begin
            r.read_data = lane;
          end
          r.status = STATUS_OK;
        end
      end
    end else if (page == PG_PEND) begin
      if (a.acc_size == SZ_WORD) begin
        set_hit = (w >= PND_SET_BASE && w < PND_SET_BASE + GRP_WORDS);
        clr_hit = (w >= PND_CLR_BASE && w < PND_CLR_BASE + GRP_WORDS);
        if (set_hit || clr_hit) begin
          idx  = set_hit ? w - PND_SET_BASE : w - PND_CLR_BASE;
          slot = a.vm_id * GRP_WORDS + idx;
          if (wr && set_hit) pending_mirror[slot] = pending_mirror[slot] | wd;
          else if (wr) pending_mirror[slot] = pending_mirror[slot] & ~wd;
          else r.read_data = pending_mirror[slot];
          r.status = STATUS_OK;
        end
      end
    end else if (page >= PG_PRI_LO && page <= PG_PRI_HI) begin
      idx = w - PRI_BASE;
      if (idx < PRI_WORDS) begin
        slot = a.vm_id * PRI_WORDS + idx;
        if (wr) prio_mirror[slot] = wd;
        else r.read_data = prio_mirror[slot];
        r.status = STATUS_OK;
      end
    end else if (page >= PG_TGT_LO && page <= PG_TGT_HI) begin
      idx = w - TGT_BASE;
      if (idx < PRI_WORDS) begin
        slot = a.vm_id * PRI_WORDS + idx;
        if (a.acc_size != SZ_RSVD) begin
          if (wr && idx > TGT_LOCKED)
            target_mirror[slot] = (target_mirror[slot] & ~(m << sh)) | ((wd & m) << sh);
          else if (!wr)
            r.read_data = (target_mirror[slot] >> sh) & m;
        end
        r.status = STATUS_OK;
      end
    end else if (page == PG_CFG) begin
      idx = w - CFG_BASE;
      if (idx < CFG_WORDS) begin
        slot = a.vm_id * CFG_WORDS + idx;
        if (wr) trigger_mirror[slot] = wd;
        else r.read_data = trigger_mirror[slot];
        r.status = STATUS_OK;
      end
    end
    return r;
  endfunction

  // Write data with plenty of zero lanes, full lanes and all-ones words
  function automatic logic [31:0] random_write_data();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom & 32'h0000_00FF;
      3:       return $urandom & 32'hFFFF_FF00;
      4:       return $urandom & (32'hFF << (8 * $urandom_range(0, 3)));
      default: return $urandom;
    endcase
  endfunction

  // Mostly accesses that land on mapped words, with random lanes and sizes;
  // about one in eight is pure noise across the whole window.
  function automatic idr_req_t random_access();
    idr_req_t a;
    int       pick;
    a.action      = 1'($urandom_range(0, 1));
    a.vm_id       = 2'($urandom_range(0, VMS - 1));
    a.byte_offset = 12'($urandom);
    a.acc_size    = 2'($urandom_range(0, 3));
    a.write_data  = random_write_data();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      a.byte_offset = 12'($urandom_range(0, 15));                // CTLR, TYPER, IIDR, gap
    end else if (pick < 16) begin
      a.byte_offset = 12'(4 * GRP_BASE + $urandom_range(0, 15));
    end else if (pick < 42) begin
      a.byte_offset = 12'(4 * ($urandom_range(0, 1) ? ENA_SET_BASE : ENA_CLR_BASE)
                          + $urandom_range(0, 15));
      a.acc_size = ($urandom_range(0, 9) == 0) ? SZ_RSVD : 2'($urandom_range(0, 2));
    end else if (pick < 54) begin
      a.byte_offset = 12'(4 * ($urandom_range(0, 1) ? PND_SET_BASE : PND_CLR_BASE)
                          + $urandom_range(0, 15));
      if ($urandom_range(0, 7) != 0) a.acc_size = SZ_WORD;
    end else if (pick < 64) begin
      a.byte_offset = 12'(4 * PRI_BASE + $urandom_range(0, 4 * PRI_WORDS - 1));
    end else if (pick < 80) begin
      a.byte_offset = 12'(4 * TGT_BASE + $urandom_range(0, 4 * PRI_WORDS - 1));
      a.acc_size = ($urandom_range(0, 9) == 0) ? SZ_RSVD : 2'($urandom_range(0, 2));
    end else if (pick < 88) begin
      a.byte_offset = 12'(4 * CFG_BASE + $urandom_range(0, 4 * CFG_WORDS - 1));
    end
    return a;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Offer one access after a random gap (none while calm_in or flood is set);
  // returns at the edge of its transfer with valid still high, so back-to-back accesses need no extra edge.
  task automatic offer_access(input idr_req_t req, input logic known, input idr_rsp_t rsp);
    int idle;
    idle = (calm_in || flood) ? 0 : $urandom_range(0, 4);
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    fixed_replies.push_back('{known, rsp});
    in_ch.data  <= req;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: each request transfer queues its reply, each reply transfer
  // is checked field by field against the oldest one queued.  Values are
  // read just after the edge, before any NBA of that step lands.  The
  // mirror is cleared while reset is held.
  always @(posedge clk) begin
    fixed_reply_t fixed;
    idr_rsp_t     want;
    idr_rsp_t     got;
    if (rst_n !== 1'b1) begin
      foreach (ctlr_mirror[i])    ctlr_mirror[i]    = '0;
      foreach (group_mirror[i])   group_mirror[i]   = '0;
      foreach (enable_mirror[i])  enable_mirror[i]  = '0;
      foreach (pending_mirror[i]) pending_mirror[i] = '0;
      foreach (prio_mirror[i])    prio_mirror[i]    = '0;
      foreach (target_mirror[i])  target_mirror[i]  = '0;
      foreach (trigger_mirror[i]) trigger_mirror[i] = '0;
    end else begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        fixed = fixed_replies.pop_front();
        want  = predict_access(in_ch.data);
        replies_due.push_back(fixed.known ? fixed.rsp : want);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = out_ch.data;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          report_field("read_data",      want.read_data,      got.read_data);
          report_field("status",         want.status,         got.status);
          report_field("enable_changed", want.enable_changed, got.enable_changed);
          report_field("changed_value",  want.changed_value,  got.changed_value);
          report_field("changed_word",   want.changed_word,   got.changed_word);
          report_field("changed_vm",     want.changed_vm,     got.changed_vm);
        end
      end
    end
  end

  // Reply side: random back-pressure before each transfer, stretches
  // with none, and one long hold-off on request from the stimulus.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_out && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = ((rx_count / 80) % 3 == 1) ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      rx_count++;
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int k;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    rst_n        <= 1'b0;
    calm_in    = 1'b0;
    flood      = 1'b0;
    hold_out   = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // in_ch.ready stays low through the clear sweep; offer_access waits it out

    for (k = 0; k < PLAN_LEN; k++)
      offer_access(ACCESS_PLAN[k].req, ACCESS_PLAN[k].known, ACCESS_PLAN[k].rsp);

    for (k = 0; k < RANDOM_ACCESSES; k++) begin
      calm_in = ((k / 96) % 3 == 2);
      flood   = (k >= FLOOD_START && k < FLOOD_END);
      // long reply hold-off while requests keep coming: the pipe fills
      // and in_ch.ready has to drop
      if (k == FLOOD_START) hold_out = 1'b1;
      // quiet point: nothing offered until every reply is back
      if (k == QUIET_POINT) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (replies_due.size() != 0 || fixed_replies.size() != 0);
      end
      offer_access(random_access(), 1'b0, RSP_OK);
    end
    in_ch.valid <= 1'b0;

    while (replies_due.size() != 0 || fixed_replies.size() != 0) @(posedge clk);
    // keep the clock running to catch any stray reply
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/idr_pkg.sv
hw/rtl/idr_if.sv
hw/rtl/idr_decode.sv
hw/rtl/idr_bank.sv
hw/rtl/idr_exec.sv
hw/rtl/interrupt_distributor_registers_top.sv
tb/interrupt_distributor_registers_top_tb.sv
